// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted (active low).
`define ASSERT_CLK_RSTN(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/pdpc_pkg.sv =====
// Package: field layout, codes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none

package pdpc_pkg;

    // fixed field widths
    localparam int SEL_W    = 5;
    localparam int WIDX_W   = 12;
    localparam int WEIGHT_W = 24;
    localparam int COUNT_W  = 16;
    localparam int ACTIVE_W = 6;
    localparam int SCORE_W  = 56;

    // input tdata layout, lowest bit up
    localparam int SEL_LSB    = 0;
    localparam int WIDX_LSB   = SEL_LSB + SEL_W;
    localparam int WEIGHT_LSB = WIDX_LSB + WIDX_W;
    localparam int COUNT_LSB  = WEIGHT_LSB + WEIGHT_W;
    localparam int IN_FIELDS_W = COUNT_LSB + COUNT_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    // output tdata layout, lowest bit up
    localparam int BEST_LSB     = 0;
    localparam int SCORE_LSB    = BEST_LSB + SEL_W;
    localparam int MARGIN_LSB   = SCORE_LSB + SCORE_W;
    localparam int OUT_FIELDS_W = MARGIN_LSB + SCORE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(32);

    // tuser codes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_COUNT = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic weight_write;  // store the incoming weight
        logic elem_load;     // latch word index and count of a count element
        logic acc_issue;     // start one accumulate step for the current profile
        logic sweep_issue;   // read one score for the argmax, clear it behind
        logic clear_issue;   // zero one accumulator (reset pass, sweep tail)
        logic diff_load;     // register best minus runner-up
        logic out_load;      // load the result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic acc_busy;      // accumulate pipeline still holds a step
        logic out_free;      // result register can take a new word
    } status_t;

endpackage

`default_nettype wire

// ===== src/pdpc_datapath.sv =====
// Datapath: weight and score memories, multiply-accumulate pipe, argmax, result register.
`timescale 1ns / 1ps
`default_nettype none

module pdpc_datapath #(
    parameter int MAX_PROFILES  = 32,
    parameter int VECTOR_LENGTH = 4096,
    parameter int PW = (MAX_PROFILES > 1) ? $clog2(MAX_PROFILES) : 1
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire  pdpc_pkg::cmd_t               cmd,
    input  wire  [PW-1:0]                      index,
    input  wire  [pdpc_pkg::SEL_W-1:0]         sel_in,
    input  wire  [pdpc_pkg::WIDX_W-1:0]        widx_in,
    input  wire  [pdpc_pkg::WEIGHT_W-1:0]      weight_in,
    input  wire  [pdpc_pkg::COUNT_W-1:0]       count_in,
    input  wire                                m_tready,
    output logic                               m_tvalid,
    output logic [pdpc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output pdpc_pkg::status_t                  status
);
    import pdpc_pkg::*;

    localparam int DEPTH = MAX_PROFILES * VECTOR_LENGTH;
    localparam int AW    = $clog2(DEPTH);

    logic [WEIGHT_W-1:0]        wmem [DEPTH];
    logic signed [SCORE_W-1:0]  amem [MAX_PROFILES];

    logic [WIDX_W-1:0]          widx_reg;
    logic [COUNT_W-1:0]         count_reg;
    logic [WEIGHT_W-1:0]        w_rd_reg;
    logic signed [SCORE_W-1:0]  acc_rd_reg;

    logic                       v1_reg, v2_reg, sv_reg;
    logic [PW-1:0]              idx1_reg, idx2_reg;
    logic signed [WEIGHT_W+COUNT_W:0] prod_reg;
    logic signed [SCORE_W-1:0]  accd_reg;

    logic signed [SCORE_W-1:0]  best_reg, second_reg;
    logic [PW-1:0]              bidx_reg;
    logic signed [SCORE_W:0]    diff_reg;

    logic                       m_tvalid_reg;
    logic [SEL_W-1:0]           out_best_reg;
    logic [SCORE_W-1:0]         out_score_reg, out_margin_reg;

    logic [AW-1:0]              wr_addr, rd_addr;
    logic signed [SCORE_W:0]    sum;
    logic signed [SCORE_W-1:0]  sat_sum;
    logic                       acc_we;
    logic [PW-1:0]              acc_wa;
    logic signed [SCORE_W-1:0]  acc_wd;
    logic [SCORE_W:0]           mag;

    assign wr_addr = AW'(int'(sel_in) * VECTOR_LENGTH + int'(widx_in));
    assign rd_addr = AW'(int'(index) * VECTOR_LENGTH + int'(widx_reg));

    always_ff @(posedge aclk) begin
        if (cmd.weight_write) begin
            wmem[wr_addr] <= weight_in;
        end
        w_rd_reg <= wmem[rd_addr];
    end

    // saturating add of the registered product
    always_comb begin
        sum = {accd_reg[SCORE_W-1], accd_reg} + (SCORE_W+1)'(prod_reg);
        if (sum[SCORE_W] != sum[SCORE_W-1]) begin
            sat_sum = sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
                                   : {1'b0, {(SCORE_W-1){1'b1}}};
        end else begin
            sat_sum = sum[SCORE_W-1:0];
        end
    end

    // pipe write-back wins; the sweep and the clear pass never overlap it
    assign acc_we = v2_reg | cmd.sweep_issue | cmd.clear_issue;
    assign acc_wa = v2_reg ? idx2_reg : index;
    assign acc_wd = v2_reg ? sat_sum : '0;

    always_ff @(posedge aclk) begin
        if (acc_we) begin
            amem[acc_wa] <= acc_wd;
        end
        acc_rd_reg <= amem[index];
    end

    always_ff @(posedge aclk) begin
        if (cmd.elem_load) begin
            widx_reg  <= widx_in;
            count_reg <= count_in;
        end
        idx1_reg <= index;
        idx2_reg <= idx1_reg;
        prod_reg <= $signed(w_rd_reg) * $signed({1'b0, count_reg});
        accd_reg <= acc_rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            sv_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.acc_issue;
            v2_reg <= v1_reg;
            sv_reg <= cmd.sweep_issue;
        end
    end

    // argmax: first strict maximum, runner-up starts at zero
    always_ff @(posedge aclk) begin
        if (sv_reg) begin
            if (idx1_reg == '0) begin
                best_reg   <= acc_rd_reg;
                second_reg <= '0;
                bidx_reg   <= '0;
            end else if (acc_rd_reg > best_reg) begin
                second_reg <= best_reg;
                best_reg   <= acc_rd_reg;
                bidx_reg   <= idx1_reg;
            end else if (acc_rd_reg > second_reg) begin
                second_reg <= acc_rd_reg;
            end
        end
        if (cmd.diff_load) begin
            diff_reg <= {best_reg[SCORE_W-1], best_reg} - {second_reg[SCORE_W-1], second_reg};
        end
    end

    assign mag = diff_reg[SCORE_W] ? (~diff_reg + (SCORE_W+1)'(1)) : diff_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_best_reg   <= SEL_W'(bidx_reg);
            out_score_reg  <= best_reg;
            out_margin_reg <= mag[SCORE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                       out_margin_reg, out_score_reg, out_best_reg};

    assign status.acc_busy = v1_reg | v2_reg;
    assign status.out_free = ~m_tvalid_reg | m_tready;

endmodule

`default_nettype wire

// ===== src/pdpc_ctrl.sv =====
// Controller: sequencing of loads, per-profile accumulate, argmax sweep and clear pass.
`timescale 1ns / 1ps
`default_nettype none

module pdpc_ctrl #(
    parameter int MAX_PROFILES  = 32,
    parameter int VECTOR_LENGTH = 4096,
    parameter int PW = (MAX_PROFILES > 1) ? $clog2(MAX_PROFILES) : 1
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_wr_en,
    input  wire  [pdpc_pkg::ACTIVE_W-1:0]    cfg_wr_data,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire                              mode,
    input  wire                              last,
    input  wire  [pdpc_pkg::SEL_W-1:0]       sel,
    input  wire  [pdpc_pkg::WIDX_W-1:0]      widx,
    input  wire  pdpc_pkg::status_t          status,
    output pdpc_pkg::cmd_t                   cmd,
    output logic [PW-1:0]                    index
);
    import pdpc_pkg::*;

    localparam int CNT_W = $clog2(MAX_PROFILES + 1);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_ACC   = 8'b0000_0100,
        ST_DRAIN = 8'b0000_1000,
        ST_SWEEP = 8'b0001_0000,
        ST_SWAIT = 8'b0010_0000,
        ST_DIFF  = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   p_reg, p_next;
    logic               last_reg, last_next;
    logic [ACTIVE_W-1:0] active_reg;
    logic [CNT_W-1:0]   n_eff;
    logic               p_at_end, p_at_max;
    logic               accept, sel_ok, widx_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACTIVE_RESET;
        end else if (cfg_wr_en) begin
            active_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if (active_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (int'(active_reg) > MAX_PROFILES) begin
            n_eff = CNT_W'(MAX_PROFILES);
        end else begin
            n_eff = CNT_W'(active_reg);
        end
    end

    assign p_at_end = (p_reg == n_eff - CNT_W'(1));
    assign p_at_max = (p_reg == CNT_W'(MAX_PROFILES - 1));
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign sel_ok   = int'(sel) < MAX_PROFILES;
    assign widx_ok  = int'(widx) < VECTOR_LENGTH;
    assign index    = p_reg[PW-1:0];

    always_comb begin
        state_next = state_reg;
        p_next     = p_reg;
        last_next  = last_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_issue = 1'b1;
                p_next = p_reg + CNT_W'(1);
                if (p_at_max) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                p_next = '0;
                if (accept) begin
                    if (mode == MODE_LOAD) begin
                        cmd.weight_write = sel_ok & widx_ok;
                    end else begin
                        cmd.elem_load = 1'b1;
                        last_next     = last;
                        if (widx_ok) begin
                            state_next = ST_ACC;
                        end else if (last) begin
                            state_next = ST_SWEEP;
                        end
                    end
                end
            end
            ST_ACC: begin
                cmd.acc_issue = 1'b1;
                p_next = p_reg + CNT_W'(1);
                if (p_at_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                p_next = '0;
                if (!status.acc_busy) begin
                    state_next = last_reg ? ST_SWEEP : ST_IDLE;
                end
            end
            ST_SWEEP: begin
                // argmax over the profiles in use; entries past them are only
                // zeroed, since a lowered count can leave scores up there
                if (p_reg < n_eff) begin
                    cmd.sweep_issue = 1'b1;
                end else begin
                    cmd.clear_issue = 1'b1;
                end
                p_next = p_reg + CNT_W'(1);
                if (p_at_max) begin
                    state_next = ST_SWAIT;
                end
            end
            ST_SWAIT: begin
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.diff_load = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            p_reg     <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            p_reg     <= p_next;
            last_reg  <= last_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/profile_dot_product_classifier_core.sv =====
// Top level of the profile dot-product classifier.
//
// Use:
//  - s_ channel takes one word per element. tuser = mode: 0 loads one profile
//    weight into the table, 1 delivers one (word index, count) element of a
//    fragment; tlast marks the final count element of the fragment.
//  - m_ channel gives one word per fragment: best profile, its score and the
//    margin to the runner-up.
//  - cfg_wr_en / cfg_wr_data write active_profiles; write it only while idle.
// Steps (n = profiles in use):
//  - an in-range count element runs one accumulate step per profile
//    through the score memory read port, then drains the multiply/add pipe.
//  - a last element adds a pass over every score entry (argmax over the n
//    in use, each zeroed behind the read), the margin, and the result load.
// Reset: the weight table keeps its contents; the score memory is zeroed by
// a clearing pass over every entry during which s_tready stays low.
// Stall: the result waits in the output register while new elements are
// taken; only the next fragment's result waits for m_tready.
`timescale 1ns / 1ps
`default_nettype none

module profile_dot_product_classifier_core #(
    parameter int MAX_PROFILES  = 32,
    parameter int VECTOR_LENGTH = 4096
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    // configuration: active_profiles
    input  wire                               cfg_wr_en,
    input  wire  [pdpc_pkg::ACTIVE_W-1:0]     cfg_wr_data,
    // input elements
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // tdata: profile_select[4:0], word_index[16:5], profile_weight[40:17],
    //        word_count[56:41], zero pad[63:57]
    input  wire  [pdpc_pkg::IN_TDATA_W-1:0]   s_tdata,
    // tuser: mode
    input  wire                               s_tuser,
    // tlast: last_element
    input  wire                               s_tlast,
    // results
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // tdata: best_profile[4:0], best_score[60:5], margin[116:61], zero pad[119:117]
    output logic [pdpc_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import pdpc_pkg::*;

    localparam int PW = (MAX_PROFILES > 1) ? $clog2(MAX_PROFILES) : 1;

    cmd_t           cmd;
    status_t        status;
    logic [PW-1:0]  index;

    // unpack the element word
    logic [SEL_W-1:0]    sel;
    logic [WIDX_W-1:0]   widx;
    logic [WEIGHT_W-1:0] weight;
    logic [COUNT_W-1:0]  count;

    assign sel    = s_tdata[SEL_LSB    +: SEL_W];
    assign widx   = s_tdata[WIDX_LSB   +: WIDX_W];
    assign weight = s_tdata[WEIGHT_LSB +: WEIGHT_W];
    assign count  = s_tdata[COUNT_LSB  +: COUNT_W];

    // sequencing: one profile per cycle for accumulate and sweep
    pdpc_ctrl #(
        .MAX_PROFILES  (MAX_PROFILES),
        .VECTOR_LENGTH (VECTOR_LENGTH),
        .PW            (PW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .mode        (s_tuser),
        .last        (s_tlast),
        .sel         (sel),
        .widx        (widx),
        .status      (status),
        .cmd         (cmd),
        .index       (index)
    );

    // memories, MAC pipe, argmax and result register
    pdpc_datapath #(
        .MAX_PROFILES  (MAX_PROFILES),
        .VECTOR_LENGTH (VECTOR_LENGTH),
        .PW            (PW)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .index     (index),
        .sel_in    (sel),
        .widx_in   (widx),
        .weight_in (weight),
        .count_in  (count),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .status    (status)
    );

endmodule

`default_nettype wire

// ===== src/pdpc_checker.sv =====
// Port-level checker for the classifier core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pdpc_checker (
    input wire                               aclk,
    input wire                               aresetn,
    input wire                               s_tvalid,
    input wire                               s_tready,
    input wire                               s_tuser,
    input wire                               s_tlast,
    input wire                               m_tvalid,
    input wire                               m_tready,
    input wire [pdpc_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import pdpc_pkg::*;

    // a stalled result word holds
    `ASSERT_CLK_RSTN(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // reset empties the output and starts the clearing pass
    `ASSERT_CLK(a_reset_state, aclk, !aresetn |=> !m_tvalid && !s_tready, "output or input open right after reset")

    // a weight load never produces a result
    `ASSERT_CLK_RSTN(a_load_no_result, aclk, aresetn, s_tvalid && s_tready && s_tuser == MODE_LOAD && !m_tvalid |=> !m_tvalid, "weight load produced a result")

    // the last element of a fragment always starts work that closes the input
    `ASSERT_CLK_RSTN(a_last_busy, aclk, aresetn, s_tvalid && s_tready && s_tuser == MODE_COUNT && s_tlast |=> !s_tready, "input stayed open after last element")

endmodule

bind profile_dot_product_classifier_core pdpc_checker u_checker (.*);

`default_nettype wire
